### hw/rtl/fsq_pkg.sv
// Package for the four-sum quadruplet search unit: codes, widths, defaults.
// No dependencies.
`default_nettype none
package fsq_pkg;
    localparam int StoreDepthDefault = 64;
    localparam int ValW = 16;
    localparam int SumW = 18;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_FETCH = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_QUAD  = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    localparam logic [1:0] REG_TARGET = 2'd0;
endpackage
`default_nettype wire

### hw/rtl/fsq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module fsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### hw/rtl/four_sum_quadruplet_search_unit.sv
// Four-sum quadruplet search unit: sorted store plus resumable two-pointer search.
// Depends on fsq_pkg and fsq_ram.
// A load shifts each larger entry up one slot before it writes the new value; a fetch
// reads four entries per pointer step and skips duplicate entries after a match and at
// an outer index, all through the single RAM port.
// Throughput: one word at a time, busy high until the result strobe.
// Reset (synchronous, active low) empties the store and zeroes r_target.
`default_nettype none
module four_sum_quadruplet_search_unit #(
    parameter int STORE_DEPTH = fsq_pkg::StoreDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic signed [15:0] i_value,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic signed [15:0] o_smallest,
    output logic signed [15:0] o_second_value,
    output logic signed [15:0] o_third_value,
    output logic signed [15:0] o_largest,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fsq_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;
    localparam int NW = SumW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_LD_RD, S_LD_WT, S_LD_CMP, S_LD_PUT,
        S_F_TOP, S_RD_A, S_RD_B, S_RD_L, S_RD_H, S_CATCH,
        S_EVAL, S_SKL, S_SKH, S_NXS, S_NXF, S_OUT
    } t_state;

    t_state r_state, r_ret;
    t_phase r_phase;
    logic [CW-1:0] r_cnt, r_fi, r_si, r_lo, r_hi, r_p;
    logic signed [SumW-1:0] r_target;
    logic signed [ValW-1:0] r_a, r_b, r_lv, r_hv, r_tmp, r_v;
    logic [1:0] r_status;
    logic [1:0] r_sel;

    logic we;
    logic [AW-1:0] addr;
    logic [ValW-1:0] wdata, rdata;
    logic signed [ValW-1:0] rd_s;
    logic signed [NW-1:0] need, s2;
    logic nx_last, nx_diff, nx_done;
    logic [CW-1:0] nx_res;

    fsq_ram #(.WIDTH(ValW), .DEPTH(STORE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign rd_s = signed'(rdata);
    assign need = NW'(r_target) - NW'(r_a) - NW'(r_b);
    assign s2 = NW'(r_lv) + NW'(r_hv);
    assign busy = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TARGET) ? {{(32-SumW){r_target[SumW-1]}}, r_target} : 32'd0;

    // duplicate walk: r_tmp holds the first entry, r_p the entry being compared
    assign nx_last = (r_p >= r_cnt - CW'(1));
    assign nx_diff = (r_sel == 2'd3) && (rd_s != r_tmp);
    assign nx_done = ((r_sel == 2'd1) && nx_last) || ((r_sel == 2'd3) && (nx_diff || nx_last));
    assign nx_res = nx_diff ? r_p : r_p + CW'(1);

    // one RAM port shared by all steps
    always_comb begin
        we = 1'b0;
        wdata = r_tmp;
        addr = r_p[AW-1:0];
        unique case (r_state)
            S_LD_RD: addr = AW'(r_p - CW'(1));
            S_LD_CMP: begin
                we = (r_p != '0) && (r_tmp > r_v);
                addr = r_p[AW-1:0];
            end
            S_LD_PUT: begin
                we = 1'b1;
                wdata = r_v;
            end
            S_RD_A: addr = r_fi[AW-1:0];
            S_RD_B: addr = r_si[AW-1:0];
            S_RD_L: addr = r_lo[AW-1:0];
            S_RD_H: addr = r_hi[AW-1:0];
            default: addr = r_p[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_phase <= PH_IDLE;
            r_cnt <= '0;
            r_fi <= '0; r_si <= '0; r_lo <= '0; r_hi <= '0; r_p <= '0;
            r_target <= '0;
            r_sel <= '0;
            r_status <= ST_OK;
            o_status <= '0;
            o_smallest <= '0; o_second_value <= '0;
            o_third_value <= '0; o_largest <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_TARGET) begin
                r_target <= pwdata[SumW-1:0];
                r_phase <= PH_IDLE;
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_status <= ST_OK;
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            r_cnt <= '0;
                            r_phase <= PH_IDLE;
                            r_state <= S_OUT;
                        end
                        MODE_LOAD: begin
                            r_phase <= PH_IDLE;
                            r_v <= i_value;
                            r_p <= r_cnt;
                            if (r_cnt >= DEPTH_C) begin
                                r_status <= ST_FULL;
                                r_state <= S_OUT;
                            end else if (r_cnt == '0) begin
                                r_state <= S_LD_PUT;
                            end else begin
                                r_state <= S_LD_RD;
                            end
                        end
                        MODE_FETCH: begin
                            if (r_phase == PH_IDLE) begin
                                r_fi <= '0;
                                r_si <= CW'(1);
                                r_lo <= CW'(2);
                                r_hi <= r_cnt - CW'(1);
                                r_phase <= PH_SEARCH;
                                r_state <= S_F_TOP;
                            end else if (r_phase == PH_SEARCH) begin
                                r_state <= S_F_TOP;
                            end else begin
                                r_status <= ST_DONE;
                                r_state <= S_OUT;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_LD_RD: r_state <= S_LD_WT;
                S_LD_WT: begin
                    r_tmp <= rd_s;
                    r_state <= S_LD_CMP;
                end
                S_LD_CMP: begin
                    // shift the larger entry up one slot
                    if (r_tmp > r_v) begin
                        r_p <= r_p - CW'(1);
                        r_state <= (r_p == CW'(1)) ? S_LD_PUT : S_LD_RD;
                    end else begin
                        r_state <= S_LD_PUT;
                    end
                end
                S_LD_PUT: begin
                    r_cnt <= r_cnt + CW'(1);
                    r_state <= S_OUT;
                end
                S_F_TOP: begin
                    if (r_fi >= r_cnt) begin
                        r_phase <= PH_DONE;
                        r_status <= ST_DONE;
                        r_state <= S_OUT;
                    end else if (r_si >= r_cnt) begin
                        r_p <= r_fi;
                        r_state <= S_NXF;
                        r_sel <= 2'd0;
                    end else if (r_lo < r_hi) begin
                        r_state <= S_RD_A;
                    end else begin
                        r_p <= r_si;
                        r_state <= S_NXS;
                        r_sel <= 2'd0;
                    end
                end
                S_RD_A: begin r_ret <= S_RD_B; r_sel <= 2'd0; r_state <= S_CATCH; end
                S_RD_B: begin r_ret <= S_RD_L; r_sel <= 2'd1; r_state <= S_CATCH; end
                S_RD_L: begin r_ret <= S_RD_H; r_sel <= 2'd2; r_state <= S_CATCH; end
                S_RD_H: begin r_ret <= S_EVAL; r_sel <= 2'd3; r_state <= S_CATCH; end
                S_CATCH: begin
                    unique case (r_sel)
                        2'd0: r_a <= rd_s;
                        2'd1: r_b <= rd_s;
                        2'd2: r_lv <= rd_s;
                        default: r_hv <= rd_s;
                    endcase
                    r_state <= r_ret;
                end
                S_EVAL: begin
                    if (s2 == need) begin
                        o_smallest <= r_a; o_second_value <= r_b;
                        o_third_value <= r_lv; o_largest <= r_hv;
                        r_status <= ST_QUAD;
                        r_p <= r_lo;
                        r_sel <= 2'd0;
                        r_state <= S_SKL;
                    end else begin
                        if (s2 > need) r_hi <= r_hi - CW'(1);
                        else r_lo <= r_lo + CW'(1);
                        r_state <= S_F_TOP;
                    end
                end
                S_SKL: begin
                    // r_sel: 0 issue read, 1 wait, 2 compare
                    if (r_sel == 2'd0) begin
                        if (r_lo <= r_hi) begin r_p <= r_lo; r_sel <= 2'd1; end
                        else begin r_p <= r_hi; r_state <= S_SKH; end
                    end else if (r_sel == 2'd1) begin
                        r_sel <= 2'd2;
                    end else begin
                        r_sel <= 2'd0;
                        if (rd_s == r_lv) r_lo <= r_lo + CW'(1);
                        else begin r_p <= r_hi; r_state <= S_SKH; end
                    end
                end
                S_SKH: begin
                    if (r_sel == 2'd0) begin
                        if (r_lo <= r_hi) begin r_p <= r_hi; r_sel <= 2'd1; end
                        else r_state <= S_OUT;
                    end else if (r_sel == 2'd1) begin
                        r_sel <= 2'd2;
                    end else begin
                        r_sel <= 2'd0;
                        if (rd_s == r_hv) r_hi <= r_hi - CW'(1);
                        else r_state <= S_OUT;
                    end
                end
                S_NXS, S_NXF: begin
                    // r_sel: 0 read first, 1 latch first, 2 read next, 3 compare
                    if (nx_done) begin
                        r_sel <= 2'd0;
                        r_state <= S_F_TOP;
                        r_hi <= r_cnt - CW'(1);
                        if (r_state == S_NXS) begin
                            r_si <= nx_res;
                            r_lo <= nx_res + CW'(1);
                        end else begin
                            r_fi <= nx_res;
                            r_si <= nx_res + CW'(1);
                            r_lo <= nx_res + CW'(2);
                        end
                    end else begin
                        unique case (r_sel)
                            2'd0: r_sel <= 2'd1;
                            2'd1: begin
                                r_tmp <= rd_s;
                                r_p <= r_p + CW'(1);
                                r_sel <= 2'd2;
                            end
                            2'd2: r_sel <= 2'd3;
                            default: begin
                                r_p <= r_p + CW'(1);
                                r_sel <= 2'd2;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    o_strobe <= 1'b1;
                    o_status <= r_status;
                    if (r_status != ST_QUAD) begin
                        o_smallest <= '0; o_second_value <= '0;
                        o_third_value <= '0; o_largest <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("entry count above depth");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");
    a_quad_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_QUAD) |-> r_phase == PH_SEARCH)
        else $error("quadruplet outside search");
endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for four_sum_quadruplet_search_unit: directed and random command words,
// checked against an in-bench sorted-store / two-pointer search predictor.
// Depends on fsq_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fsq_pkg::*;

    typedef struct {
        t_status          st;
        logic [3:0][15:0] q;
    } t_quad_word;

    class quad_scoreboard;
        int       store[64];
        int       count;
        int       fi, si, lo, hi;
        t_phase   ph;
        int       target;
        t_quad_word pending_q[$];
        int       errors;

        function void reset_state();
            count = 0; fi = 0; si = 0; lo = 0; hi = 0;
            ph = PH_IDLE; target = 0; errors = 0;
        endfunction

        function void set_target(int t);
            target = t;
            ph = PH_IDLE;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function bit find_next(output int q[4]);
            int a, b, lv, hv, need, s;
            q = '{0, 0, 0, 0};
            if (ph == PH_IDLE) begin
                fi = 0; si = 1; lo = 2; hi = count - 1;
                ph = PH_SEARCH;
            end
            if (ph != PH_SEARCH) return 0;
            forever begin
                if (fi >= count) begin
                    ph = PH_DONE;
                    return 0;
                end
                if (si >= count) begin
                    while (fi < count - 1 && store[fi] == store[fi + 1]) fi++;
                    fi++;
                    si = fi + 1; lo = si + 1; hi = count - 1;
                    continue;
                end
                if (lo < hi) begin
                    a = store[fi]; b = store[si]; lv = store[lo]; hv = store[hi];
                    need = target - a - b;
                    s = lv + hv;
                    if (s == need) begin
                        q = '{a, b, lv, hv};
                        while (lo <= hi && store[lo] == lv) lo++;
                        while (lo <= hi && store[hi] == hv) hi--;
                        return 1;
                    end else if (s > need) begin
                        hi--;
                    end else begin
                        lo++;
                    end
                end else begin
                    while (si < count - 1 && store[si] == store[si + 1]) si++;
                    si++;
                    lo = si + 1; hi = count - 1;
                end
            end
        endfunction

        function void note(t_mode m, logic signed [15:0] value);
            t_quad_word w;
            int       q[4];
            int       p;
            w.st = ST_OK;
            w.q  = '0;
            case (m)
                MODE_CLEAR: begin
                    count = 0;
                    ph = PH_IDLE;
                end
                MODE_LOAD: begin
                    ph = PH_IDLE;
                    if (count >= 64) begin
                        w.st = ST_FULL;
                    end else begin
                        p = count;
                        while (p > 0 && store[p - 1] > int'(value)) begin
                            store[p] = store[p - 1];
                            p--;
                        end
                        store[p] = value;
                        count++;
                    end
                end
                MODE_FETCH: begin
                    if (find_next(q)) begin
                        w.st = ST_QUAD;
                        for (int k = 0; k < 4; k++) w.q[k] = q[k][15:0];
                    end else begin
                        w.st = ST_DONE;
                    end
                end
                default: ;
            endcase
            pending_q = {pending_q, w};
        endfunction

        function void check(logic [1:0] st, logic [3:0][15:0] q);
            t_quad_word w;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: status %0d", st);
                return;
            end
            w = pending_q.pop_front();
            if (st !== w.st || q !== w.q) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d q=%h  got st=%0d q=%h",
                             w.st, w.q, st, q);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_mode = '0;
    logic signed [15:0] i_value = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic signed [15:0] o_smallest, o_second_value, o_third_value, o_largest;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quad_scoreboard sb = new();
    int idle_pct;
    int sent;

    four_sum_quadruplet_search_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_value(i_value), .o_strobe(o_strobe), .o_status(o_status),
        .o_smallest(o_smallest), .o_second_value(o_second_value),
        .o_third_value(o_third_value), .o_largest(o_largest),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note(t_mode'(i_mode), i_value);
        if (i_rst_n && o_strobe)
            sb.check(o_status, {o_largest, o_third_value, o_second_value, o_smallest});
    end

    task automatic send(t_mode m, logic [15:0] v);
        start  <= 1'b1;
        i_mode <= m;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_target(int t);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_TARGET; pwdata <= t;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_target(t);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_value(bit wide);
        if (wide || $urandom_range(9) == 0) return 16'($urandom());
        return 16'($urandom_range(16) - 8);
    endfunction

    task automatic random_phase(int goal, int tgt, bit wide);
        int n;
        write_target(tgt);
        while (sent < goal) begin
            send(MODE_CLEAR, 16'($urandom()));
            n = $urandom_range(4, 10);
            repeat (n) send(MODE_LOAD, rand_value(wide));
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(9))
                    0: send(MODE_NONE, 16'($urandom()));
                    1: send(MODE_LOAD, rand_value(wide));
                    default: send(MODE_FETCH, 16'($urandom()));
                endcase
            end
            if ($urandom_range(7) == 0) drain();
        end
    endtask

    initial begin
        sb.reset_state();
        idle_pct = 0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, short store, restart on load
        write_target(-131072);
        send(MODE_FETCH, 16'h0);
        repeat (4) send(MODE_LOAD, 16'h8000);
        send(MODE_FETCH, 16'hffff);
        send(MODE_FETCH, 16'h0);
        send(MODE_NONE, 16'hffff);
        send(MODE_FETCH, 16'h0);
        send(MODE_LOAD, 16'h7fff);
        send(MODE_LOAD, 16'hffff);
        send(MODE_FETCH, 16'h0);
        send(MODE_FETCH, 16'h0);
        write_target(131071);
        send(MODE_FETCH, 16'h0);
        send(MODE_CLEAR, 16'hffff);
        repeat (4) send(MODE_LOAD, 16'h7fff);
        send(MODE_FETCH, 16'h0);
        write_target(131068);
        send(MODE_FETCH, 16'h0);
        send(MODE_FETCH, 16'h0);
        // full store, overflow drop
        write_target(20);
        send(MODE_CLEAR, 16'h0);
        repeat (65) send(MODE_LOAD, 16'd5);
        send(MODE_FETCH, 16'h0);
        send(MODE_FETCH, 16'h0);
        send(MODE_CLEAR, 16'h0);

        random_phase(200, $urandom_range(20) - 10, 0);
        idle_pct = 66;
        random_phase(320, 0, 0);
        idle_pct = 0;
        random_phase(440, $urandom_range(20) - 10, 0);
        idle_pct = 33;
        random_phase(560, int'({{14{1'b0}}, 18'($urandom())} << 14) >>> 14, 1);

        drain();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
